// ===== hw/rtl/sps_pkg.sv =====
// Shared types and opcode constants for the stereo PCM sample queue.
`timescale 1ns / 1ps
package sps_pkg;

	typedef logic [2:0] opcode_t;
	typedef logic [7:0] sample_t;

	localparam opcode_t OP_WRITE = 3'd0;
	localparam opcode_t OP_TICK  = 3'd1;
	localparam opcode_t OP_FLUSH = 3'd2;
	localparam opcode_t OP_START = 3'd3;
	localparam opcode_t OP_STOP  = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // capture the item and launch the ring read
		logic exec;  // apply the item to the ring and the levels
	} sps_cmd_t;

endpackage

// ===== hw/rtl/sps_ctrl.sv =====
// Controller state machine: sequences load and execute, drives busy and done.
`timescale 1ns / 1ps
module sps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output sps_pkg::sps_cmd_t cmd
);
	import sps_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// results are registered at this edge, so flag them next cycle
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q == ST_EXEC);
	assign done     = done_q;
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign cmd.exec = (state_q == ST_EXEC);

endmodule

// ===== hw/rtl/sps_datapath.sv =====
// Datapath: sample ring memory, ring indices, held pair, levels and run flag.
`timescale 1ns / 1ps
module sps_datapath #(
	parameter int RING_DEPTH = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sps_pkg::sps_cmd_t cmd,
	input  sps_pkg::opcode_t  opcode,
	input  sps_pkg::sample_t  left_sample,
	input  sps_pkg::sample_t  right_sample,
	output logic              accepted,
	output sps_pkg::sample_t  level_left,
	output sps_pkg::sample_t  level_right,
	output logic              running
);
	import sps_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

	logic [15:0]   mem_q [RING_DEPTH];
	logic [15:0]   rd_data_q;
	opcode_t       op_q;
	sample_t       left_q;
	sample_t       right_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] wr_idx_q;
	sample_t       held_left_q;
	sample_t       held_right_q;
	sample_t       shown_left_q;
	sample_t       shown_right_q;
	logic          enabled_q;
	logic          accepted_q;

	logic [AW-1:0] rd_next;
	logic [AW-1:0] wr_next;
	logic          ring_empty;
	logic          ring_full;
	logic          mem_we;

	assign rd_next    = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + AW'(1);
	assign wr_next    = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + AW'(1);
	assign ring_empty = (rd_idx_q == wr_idx_q);
	// keep one slot empty so full and empty stay distinct
	assign ring_full  = (wr_next == rd_idx_q);
	assign mem_we     = cmd.exec && (op_q == OP_WRITE) && enabled_q && !ring_full;

	// Capture the item and read the oldest pair while it is loaded.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= opcode;
			left_q    <= left_sample;
			right_q   <= right_sample;
			rd_data_q <= mem_q[rd_idx_q];
		end
		if (mem_we) begin
			mem_q[wr_idx_q] <= {left_q, right_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q      <= '0;
			wr_idx_q      <= '0;
			held_left_q   <= '0;
			held_right_q  <= '0;
			shown_left_q  <= '0;
			shown_right_q <= '0;
			enabled_q     <= 1'b0;
			accepted_q    <= 1'b0;
		end else if (cmd.exec) begin
			accepted_q <= 1'b0;
			case (op_q)
				OP_WRITE: begin
					if (mem_we) begin
						wr_idx_q   <= wr_next;
						accepted_q <= 1'b1;
					end
				end
				OP_TICK: begin
					if (enabled_q) begin
						if (!ring_empty) begin
							held_left_q   <= rd_data_q[15:8];
							held_right_q  <= rd_data_q[7:0];
							shown_left_q  <= rd_data_q[15:8];
							shown_right_q <= rd_data_q[7:0];
							rd_idx_q      <= rd_next;
						end else begin
							// ring ran dry: repeat the last pair
							shown_left_q  <= held_left_q;
							shown_right_q <= held_right_q;
						end
					end
				end
				OP_FLUSH: begin
					rd_idx_q      <= wr_idx_q;
					held_left_q   <= '0;
					held_right_q  <= '0;
					shown_left_q  <= '0;
					shown_right_q <= '0;
				end
				OP_START, OP_STOP: begin
					rd_idx_q      <= '0;
					wr_idx_q      <= '0;
					held_left_q   <= '0;
					held_right_q  <= '0;
					shown_left_q  <= '0;
					shown_right_q <= '0;
					enabled_q     <= (op_q == OP_START);
				end
				default: begin
				end
			endcase
		end
	end

	assign accepted    = accepted_q;
	assign level_left  = shown_left_q;
	assign level_right = shown_right_q;
	assign running     = enabled_q;

endmodule

// ===== hw/rtl/stereo_pcm_sample_fifo.sv =====
// Top level of the stereo PCM sample queue: controller plus datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  command  | start / busy         | opcode, left_sample, right_sample
//  result   | done (one-cycle)     | accepted, level_left, level_right, running
//
// An item is taken when start is high and busy is low. Busy is then high for
// one cycle while the item is applied, and done pulses in the following cycle,
// once the results are registered; the ring memory read is registered at load.
// A new item may be started in the cycle done is high.
// arst_n clears indices, levels, held pair and run flag; ring contents are
// left as they are and never read before being written. Results cannot stall.
`timescale 1ns / 1ps
module stereo_pcm_sample_fifo #(
	parameter int RING_DEPTH = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sps_pkg::opcode_t opcode,
	input  sps_pkg::sample_t left_sample,
	input  sps_pkg::sample_t right_sample,
	output logic             done,
	output logic             accepted,
	output sps_pkg::sample_t level_left,
	output sps_pkg::sample_t level_right,
	output logic             running
);
	import sps_pkg::*;

	sps_cmd_t cmd;

	sps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	sps_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (opcode),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.accepted     (accepted),
		.level_left   (level_left),
		.level_right  (level_right),
		.running      (running)
	);

endmodule
